// ===== hw/rtl/cfa_pkg.sv =====
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared types, command codes and divider step for the constant fold ALU.
// ----------------------------------------------------------------------------
package cfa_pkg;

	localparam int unsigned CMD_W       = 5;
	localparam int unsigned VAL_W       = 17;
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned HALF_W      = 16;
	localparam int unsigned DIV_STEPS   = 2;

	localparam logic [CMD_W-1:0] CMD_NEG  = 5'd0;
	localparam logic [CMD_W-1:0] CMD_NOT  = 5'd1;
	localparam logic [CMD_W-1:0] CMD_LNOT = 5'd2;
	localparam logic [CMD_W-1:0] CMD_CONV = 5'd3;
	localparam logic [CMD_W-1:0] CMD_ADD  = 5'd4;
	localparam logic [CMD_W-1:0] CMD_SUB  = 5'd5;
	localparam logic [CMD_W-1:0] CMD_MUL  = 5'd6;
	localparam logic [CMD_W-1:0] CMD_DIV  = 5'd7;
	localparam logic [CMD_W-1:0] CMD_MOD  = 5'd8;
	localparam logic [CMD_W-1:0] CMD_SHL  = 5'd9;
	localparam logic [CMD_W-1:0] CMD_SHR  = 5'd10;
	localparam logic [CMD_W-1:0] CMD_AND  = 5'd11;
	localparam logic [CMD_W-1:0] CMD_OR   = 5'd12;
	localparam logic [CMD_W-1:0] CMD_XOR  = 5'd13;
	localparam logic [CMD_W-1:0] CMD_EQ   = 5'd14;
	localparam logic [CMD_W-1:0] CMD_NE   = 5'd15;
	localparam logic [CMD_W-1:0] CMD_LT   = 5'd16;
	localparam logic [CMD_W-1:0] CMD_GT   = 5'd17;
	localparam logic [CMD_W-1:0] CMD_LE   = 5'd18;
	localparam logic [CMD_W-1:0] CMD_GE   = 5'd19;
	localparam logic [CMD_W-1:0] CMD_LAND = 5'd20;
	localparam logic [CMD_W-1:0] CMD_LOR  = 5'd21;

	typedef struct packed {
		logic              sel_div;
		logic              sel_mod;
		logic              rel;
		logic              one_byte;
		logic              res_unsigned;
		logic [HALF_W-1:0] value;
	} ctl_t;

	typedef struct packed {
		logic [WORD_W-1:0] rem;
		logic [WORD_W-1:0] dvd;
	} div_t;

	// one restoring step: quotient bits shift into the dividend word
	function automatic div_t div_step(input div_t cur, input logic [WORD_W-1:0] dvs);
		logic [WORD_W:0] r;
		div_t            nxt;
		r       = {cur.rem, cur.dvd[WORD_W-1]};
		nxt.dvd = {cur.dvd[WORD_W-2:0], 1'b0};
		if (r >= {1'b0, dvs}) begin
			r          = r - {1'b0, dvs};
			nxt.dvd[0] = 1'b1;
		end
		nxt.rem = r[WORD_W-1:0];
		return nxt;
	endfunction

endpackage

// ===== hw/rtl/cfa_in_if.sv =====
// ----------------------------------------------------------------------------
// cfa_in_if
// Operand channel of the constant fold ALU.
// ----------------------------------------------------------------------------
interface cfa_in_if;
	logic                            valid;
	logic                            ready;
	logic [cfa_pkg::CMD_W-1:0]       command;
	logic signed [cfa_pkg::VAL_W-1:0] left_value;
	logic signed [cfa_pkg::VAL_W-1:0] right_value;
	logic                            left_is_unsigned;
	logic                            right_is_unsigned;
	logic [1:0]                      result_bytes;
	logic                            result_is_unsigned;

	modport source (output valid, command, left_value, right_value, left_is_unsigned,
		right_is_unsigned, result_bytes, result_is_unsigned, input ready);
	modport sink (input valid, command, left_value, right_value, left_is_unsigned,
		right_is_unsigned, result_bytes, result_is_unsigned, output ready);
endinterface

// ===== hw/rtl/cfa_out_if.sv =====
// ----------------------------------------------------------------------------
// cfa_out_if
// Result channel of the constant fold ALU.
// ----------------------------------------------------------------------------
interface cfa_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [cfa_pkg::VAL_W-1:0] folded_value;

	modport source (output valid, folded_value, input ready);
	modport sink (input valid, folded_value, output ready);
endinterface

// ===== hw/rtl/constant_fold_alu_unit.sv =====
// ----------------------------------------------------------------------------
// constant_fold_alu_unit
// Folds one C operator over two extended constants in 32-bit arithmetic.
// ----------------------------------------------------------------------------
//  channel   dir   carries
//  operands  in    command, left/right value and signedness, result type
//  result    out   folded_value
//
// One transaction per cycle unless result stalls. The result passes through one input
// register, 32/DivStepsPerStage divider stages (DivStepsPerStage quotient bits
// per stage) and one output register.
// Reset clears the valid bits only. A stall on result freezes every stage;
// operands.ready is low exactly while a result waits untaken.
module constant_fold_alu_unit #(
	parameter int unsigned DivStepsPerStage = cfa_pkg::DIV_STEPS
) (
	input logic clk,
	input logic arst_n,
	cfa_in_if.sink   operands,
	cfa_out_if.source result
);
	localparam int unsigned W     = cfa_pkg::WORD_W;
	localparam int unsigned H     = cfa_pkg::HALF_W;
	localparam int unsigned NSTG  = W / DivStepsPerStage;

	logic en;
	assign en             = !result.valid || result.ready;
	assign operands.ready = en;

	logic [W-1:0] lv, rv;
	logic         sgn, lt, gt, eq, big_shift;
	cfa_pkg::ctl_t ctl_in;
	logic [H-1:0]  prod;

	assign lv  = {{(W-cfa_pkg::VAL_W){operands.left_value[cfa_pkg::VAL_W-1]}},
		operands.left_value};
	assign rv  = {{(W-cfa_pkg::VAL_W){operands.right_value[cfa_pkg::VAL_W-1]}},
		operands.right_value};
	assign sgn = !operands.left_is_unsigned && !operands.right_is_unsigned;
	assign eq  = lv == rv;
	assign lt  = sgn ? ($signed(lv) < $signed(rv)) : (lv < rv);
	assign gt  = !lt && !eq;
	assign big_shift = |rv[W-1:5];
	assign prod = H'(lv[H-1:0] * rv[H-1:0]);

	always_comb begin
		ctl_in.sel_div      = 1'b0;
		ctl_in.sel_mod      = 1'b0;
		ctl_in.rel          = 1'b0;
		ctl_in.one_byte     = operands.result_bytes == 2'd1;
		ctl_in.res_unsigned = operands.result_is_unsigned;
		ctl_in.value        = '0;
		case (operands.command)
			cfa_pkg::CMD_NEG:  ctl_in.value = H'(0 - lv[H-1:0]);
			cfa_pkg::CMD_NOT:  ctl_in.value = ~lv[H-1:0];
			cfa_pkg::CMD_LNOT: ctl_in.value = H'(lv == '0);
			cfa_pkg::CMD_CONV: ctl_in.value = lv[H-1:0];
			cfa_pkg::CMD_ADD:  ctl_in.value = H'(lv[H-1:0] + rv[H-1:0]);
			cfa_pkg::CMD_SUB:  ctl_in.value = H'(lv[H-1:0] - rv[H-1:0]);
			cfa_pkg::CMD_MUL:  ctl_in.value = prod;
			cfa_pkg::CMD_DIV: begin
				ctl_in.value   = lv[H-1:0];
				ctl_in.sel_div = rv != '0;
			end
			cfa_pkg::CMD_MOD: begin
				ctl_in.value   = lv[H-1:0];
				ctl_in.sel_mod = rv != '0;
			end
			cfa_pkg::CMD_SHL: ctl_in.value = big_shift ? '0 : H'(lv[H-1:0] << rv[4:0]);
			cfa_pkg::CMD_SHR: ctl_in.value = big_shift ? '0 : H'(lv >> rv[4:0]);
			cfa_pkg::CMD_AND: ctl_in.value = lv[H-1:0] & rv[H-1:0];
			cfa_pkg::CMD_OR:  ctl_in.value = lv[H-1:0] | rv[H-1:0];
			cfa_pkg::CMD_XOR: ctl_in.value = lv[H-1:0] ^ rv[H-1:0];
			cfa_pkg::CMD_EQ:  begin ctl_in.rel = 1'b1; ctl_in.value = H'(eq); end
			cfa_pkg::CMD_NE:  begin ctl_in.rel = 1'b1; ctl_in.value = H'(!eq); end
			cfa_pkg::CMD_LT:  begin ctl_in.rel = 1'b1; ctl_in.value = H'(lt); end
			cfa_pkg::CMD_GT:  begin ctl_in.rel = 1'b1; ctl_in.value = H'(gt); end
			cfa_pkg::CMD_LE:  begin ctl_in.rel = 1'b1; ctl_in.value = H'(!gt); end
			cfa_pkg::CMD_GE:  begin ctl_in.rel = 1'b1; ctl_in.value = H'(!lt); end
			cfa_pkg::CMD_LAND: begin
				ctl_in.rel   = 1'b1;
				ctl_in.value = H'(lv != '0 && rv != '0);
			end
			cfa_pkg::CMD_LOR: begin
				ctl_in.rel   = 1'b1;
				ctl_in.value = H'(lv != '0 || rv != '0);
			end
			default: ctl_in.value = '0;
		endcase
		if (ctl_in.rel) begin
			ctl_in.one_byte     = 1'b0;
			ctl_in.res_unsigned = 1'b0;
		end
	end

	// stage 0 is the input register, stages 1..NSTG run the divider
	logic          vld_s [0:NSTG];
	cfa_pkg::ctl_t ctl_s [0:NSTG];
	cfa_pkg::div_t div_s [0:NSTG];
	logic [W-1:0]  dvs_s [0:NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= operands.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s[0]     <= ctl_in;
			div_s[0].rem <= '0;
			div_s[0].dvd <= lv;
			dvs_s[0]     <= rv;
		end
	end

	for (genvar k = 1; k <= NSTG; k++) begin : g_div
		cfa_pkg::div_t step [0:DivStepsPerStage];

		always_comb begin
			step[0] = div_s[k-1];
			for (int j = 0; j < DivStepsPerStage; j++) begin
				step[j+1] = cfa_pkg::div_step(step[j], dvs_s[k-1]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctl_s[k] <= ctl_s[k-1];
				div_s[k] <= step[DivStepsPerStage];
				dvs_s[k] <= dvs_s[k-1];
			end
		end
	end

	cfa_pkg::ctl_t fin;
	logic [H-1:0]  fv;
	logic          ext;
	logic signed [cfa_pkg::VAL_W-1:0] wrapped;

	assign fin = ctl_s[NSTG];
	assign fv  = fin.sel_div ? div_s[NSTG].dvd[H-1:0] :
		fin.sel_mod ? div_s[NSTG].rem[H-1:0] : fin.value;

	always_comb begin
		if (fin.one_byte) begin
			ext     = !fin.res_unsigned && fv[7];
			wrapped = {{(cfa_pkg::VAL_W-8){ext}}, fv[7:0]};
		end else begin
			ext     = !fin.res_unsigned && fv[H-1];
			wrapped = {ext, fv};
		end
	end

	logic                             out_vld_q;
	logic signed [cfa_pkg::VAL_W-1:0] out_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_s[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_val_q <= wrapped;
		end
	end

	assign result.valid        = out_vld_q;
	assign result.folded_value = out_val_q;

`ifndef SYNTHESIS
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !operands.ready)
		else $error("input taken while result stalled");

	a_rel_is_bool: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NSTG] && fin.rel |-> fin.value[H-1:1] == '0 && !fin.one_byte)
		else $error("relation result not 0/1 int");

	a_div_mod_excl: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] |-> !(ctl_s[0].sel_div && ctl_s[0].sel_mod))
		else $error("divide and modulo both selected");
`endif

endmodule
